[src/binned_spectral_peak_search_top_assert.svh]
// assertion macros for the binned spectral peak search
`ifndef BINNED_SPECTRAL_PEAK_SEARCH_TOP_ASSERT_SVH
`define BINNED_SPECTRAL_PEAK_SEARCH_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BSPS_ASSERT_IMPLY(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define BSPS_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define BSPS_ASSERT_IMPLY(lbl, clk, rstn, a, b)
`define BSPS_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif

`endif

[src/bsps_pkg.sv]
`timescale 1ns / 1ps

package bsps_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int SPECTRUM_POINTS = 1024;
    localparam int POS_W           = $clog2(SPECTRUM_POINTS);
    localparam int CFG_W           = POS_W + 1;
    localparam int FLOOR_W         = 24;
    localparam int POW_W           = 2 * SAMPLE_BITS;
    localparam int CFG_DATA_W      = 24;
    localparam int CFG_IDX_W       = 3;
    localparam int MAX_BINS_DEF    = 64;
    localparam int SQ_STEPS        = POW_W / 2;
    localparam int CNT_W           = $clog2(SQ_STEPS);
    localparam int MUL_STEPS       = 3;
    localparam int IN_TD_W         = ((POS_W + 2 * SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONJUGATE_MODE = 3'd4;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_CALC, ST_READ, ST_UPD, ST_DUMP, ST_ERR,
        ST_BIN_RD, ST_SQ_INIT, ST_SQ, ST_LOAD, ST_OUT, ST_PRIME
    } t_state;

    typedef enum logic [1:0] {MUL_RE, MUL_IM, MUL_FLOOR} t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum_en;
        logic     acc_rd;
        logic     acc_upd;
        logic     dump_init;
        logic     bin_rd;
        logic     sq_init;
        logic     sq_step;
        logic     out_load;
        logic     out_err;
        logic     bin_next;
        logic     prime;
    } t_cmd;

    typedef struct packed {
        logic too_many;
        logic empty;
        logic last_item;
        logic out_fire;
        logic out_last;
    } t_status;

    typedef struct packed {
        logic        [POW_W-1:0]       power;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic        [POS_W-1:0]       pos;
    } t_entry;

    function automatic int bin_w(input int max_bins);
        return (max_bins > 1) ? $clog2(max_bins) : 1;
    endfunction

    function automatic int out_td_w(input int max_bins);
        return ((bin_w(max_bins) + POS_W + 3 * SAMPLE_BITS + 7) / 8) * 8;
    endfunction

endpackage

[src/bsps_ram.sv]
`timescale 1ns / 1ps

module bsps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/bsps_datapath.sv]
`timescale 1ns / 1ps

module bsps_datapath import bsps_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic [POS_W-1:0]              i_pos,
    input  logic signed [SAMPLE_BITS-1:0] i_re,
    input  logic signed [SAMPLE_BITS-1:0] i_im,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bin_w(MAX_BINS)-1:0]    o_bin,
    output logic                          o_found,
    output logic [POS_W-1:0]              o_pos,
    output logic signed [SAMPLE_BITS-1:0] o_re,
    output logic signed [SAMPLE_BITS-1:0] o_im,
    output logic [SAMPLE_BITS-1:0]        o_mag,
    output logic                          o_too_many,
    output logic                          o_last
);

    localparam int AW     = bin_w(MAX_BINS);
    localparam int DVW    = CFG_W + AW - 1;
    localparam int MBW    = $clog2(MAX_BINS + 1);
    localparam int LW     = CFG_W + MBW;
    localparam int BASE_W = CFG_W + 1;

    // configuration
    logic [CFG_W-1:0]   r_ws, r_we, r_bw;
    logic [FLOOR_W-1:0] r_floor;
    logic               r_conj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws    <= '0;
            r_we    <= CFG_W'(SPECTRUM_POINTS);
            r_bw    <= CFG_W'(SPECTRUM_POINTS);
            r_floor <= '0;
            r_conj  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WINDOW_START:   r_ws    <= i_cfg_data[CFG_W-1:0];
                CFG_WINDOW_END:     r_we    <= i_cfg_data[CFG_W-1:0];
                CFG_BIN_WIDTH:      r_bw    <= i_cfg_data[CFG_W-1:0];
                CFG_FLOOR_LEVEL:    r_floor <= i_cfg_data[FLOOR_W-1:0];
                CFG_CONJUGATE_MODE: r_conj  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [CFG_W-1:0] bw_eff, len;
    logic [LW-1:0]    lim;
    logic             empty, too_many, floor_zero;

    always_comb begin
        bw_eff     = (r_bw == '0) ? CFG_W'(1) : r_bw;
        empty      = (r_we <= r_ws);
        len        = r_we - r_ws;
        lim        = LW'(MAX_BINS) * LW'(bw_eff);
        too_many   = !empty && (LW'(len) > lim);
        floor_zero = (r_floor == '0);
    end

    // item capture and bin index division
    logic [POS_W-1:0]              r_pos;
    logic signed [SAMPLE_BITS-1:0] r_re, r_im;
    logic [SAMPLE_BITS-1:0]        r_ar, r_ai;
    logic                          r_last, r_hit;
    logic [CFG_W-1:0]              r_rem;
    logic [DVW-1:0]                r_dv;
    logic [AW-1:0]                 r_q;
    logic [SAMPLE_BITS-1:0]        in_ar, in_ai;
    logic                          in_win;

    always_comb begin
        in_ar  = i_re[SAMPLE_BITS-1] ? SAMPLE_BITS'(~i_re + 1'b1) : SAMPLE_BITS'(i_re);
        in_ai  = i_im[SAMPLE_BITS-1] ? SAMPLE_BITS'(~i_im + 1'b1) : SAMPLE_BITS'(i_im);
        in_win = (CFG_W'(i_pos) >= r_ws) && (CFG_W'(i_pos) < r_we);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos  <= i_pos;
            r_re   <= i_re;
            r_im   <= i_im;
            r_ar   <= in_ar;
            r_ai   <= in_ai;
            r_last <= i_last;
            r_hit  <= in_win && !too_many;
            r_rem  <= CFG_W'(i_pos) - r_ws;
            r_dv   <= DVW'(bw_eff) << (AW - 1);
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            if (DVW'(r_rem) >= r_dv) begin
                r_rem <= r_rem - CFG_W'(r_dv);
                r_q   <= (r_q << 1) | AW'(1);
            end else begin
                r_q   <= r_q << 1;
            end
            r_dv <= r_dv >> 1;
        end
    end

    // shared multiplier
    logic [SAMPLE_BITS-1:0] mul_a;
    logic [POW_W-1:0]       mul_p;
    logic [POW_W-1:0]       r_sq_re, r_sq_im, r_fsq, r_pow;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_RE:  mul_a = r_ar;
            MUL_IM:  mul_a = r_ai;
            default: mul_a = SAMPLE_BITS'(r_floor);
        endcase
        mul_p = POW_W'(mul_a) * POW_W'(mul_a);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_RE:  r_sq_re <= mul_p;
                MUL_IM:  r_sq_im <= mul_p;
                default: r_fsq   <= mul_p;
            endcase
        end
        if (i_cmd.sum_en) begin
            r_pow <= r_sq_re + r_sq_im;
        end
    end

    // bin store
    logic [MAX_BINS-1:0] r_valid;
    logic [AW-1:0]       r_j;
    logic [BASE_W-1:0]   r_base;
    t_entry              rd_ent, wr_ent;
    logic [AW-1:0]       rd_addr;
    logic                better, above, wr_en, last_bin;

    always_comb begin
        rd_addr = i_cmd.bin_rd ? r_j : r_q;
        above   = floor_zero || (r_pow > r_fsq);
        better  = !r_valid[r_q] || (r_pow > rd_ent.power) ||
                  ((r_pow == rd_ent.power) && (r_pos < rd_ent.pos));
        wr_en   = i_cmd.acc_upd && r_hit && above && better;
        wr_ent  = '{power: r_pow, re: r_re, im: r_im, pos: r_pos};
        last_bin = (r_base + BASE_W'(bw_eff)) >= BASE_W'(len);
    end

    bsps_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_q),
        .i_wr_data (wr_ent),
        .i_rd_en   (i_cmd.acc_rd || i_cmd.bin_rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_ent)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.prime) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_q] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dump_init) begin
            r_j    <= '0;
            r_base <= '0;
        end else if (i_cmd.bin_next) begin
            r_j    <= r_j + 1'b1;
            r_base <= r_base + BASE_W'(bw_eff);
        end
    end

    // integer square root, two bits per step
    t_entry           r_ent;
    logic             r_ok;
    logic [POW_W-1:0] r_x, r_res, r_bit;
    logic [POW_W-1:0] sq_try;

    assign sq_try = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init) begin
            r_ent <= rd_ent;
            r_ok  <= r_valid[r_j] && (floor_zero || (rd_ent.power > r_fsq));
            r_x   <= rd_ent.power;
            r_res <= '0;
            r_bit <= POW_W'(1) << (POW_W - 2);
        end else if (i_cmd.sq_step) begin
            if (r_x >= sq_try) begin
                r_x   <= r_x - sq_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // output register
    logic                          r_o_valid;
    logic [AW-1:0]                 r_o_bin;
    logic                          r_o_found, r_o_too_many, r_o_last;
    logic [POS_W-1:0]              r_o_pos;
    logic signed [SAMPLE_BITS-1:0] r_o_re, r_o_im;
    logic [SAMPLE_BITS-1:0]        r_o_mag;
    logic signed [SAMPLE_BITS-1:0] rep_im;
    logic                          out_fire;

    always_comb begin
        if (!r_conj) begin
            rep_im = r_ent.im;
        end else if (r_ent.im == SMP_MIN) begin
            rep_im = SMP_MAX;
        end else begin
            rep_im = -r_ent.im;
        end
        out_fire = r_o_valid && i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load || i_cmd.out_err) begin
            r_o_valid <= 1'b1;
        end else if (out_fire) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_err) begin
            r_o_bin      <= '0;
            r_o_found    <= 1'b0;
            r_o_pos      <= '0;
            r_o_re       <= '0;
            r_o_im       <= '0;
            r_o_mag      <= '0;
            r_o_too_many <= 1'b1;
            r_o_last     <= 1'b1;
        end else if (i_cmd.out_load) begin
            r_o_bin      <= r_j;
            r_o_found    <= r_ok;
            r_o_pos      <= r_ok ? r_ent.pos : '0;
            r_o_re       <= r_ok ? r_ent.re : '0;
            r_o_im       <= r_ok ? rep_im : '0;
            r_o_mag      <= r_ok ? r_res[SAMPLE_BITS-1:0] : '0;
            r_o_too_many <= 1'b0;
            r_o_last     <= last_bin;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_bin      = r_o_bin;
    assign o_found    = r_o_found;
    assign o_pos      = r_o_pos;
    assign o_re       = r_o_re;
    assign o_im       = r_o_im;
    assign o_mag      = r_o_mag;
    assign o_too_many = r_o_too_many;
    assign o_last     = r_o_last;

    assign o_status = '{too_many: too_many, empty: empty, last_item: r_last,
                        out_fire: out_fire, out_last: r_o_last};

endmodule

[src/bsps_ctrl.sv]
`timescale 1ns / 1ps

module bsps_ctrl import bsps_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int QW     = bin_w(MAX_BINS);
    localparam int CALC_N = (QW > MUL_STEPS + 1) ? QW : MUL_STEPS + 1;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_CALC;
            ST_CALC:    if (r_cnt == CNT_W'(CALC_N - 1)) n_state = ST_READ;
            ST_READ:    n_state = ST_UPD;
            ST_UPD:     n_state = i_status.last_item ? ST_DUMP : ST_IDLE;
            ST_DUMP: begin
                if (i_status.too_many) begin
                    n_state = ST_ERR;
                end else if (i_status.empty) begin
                    n_state = ST_PRIME;
                end else begin
                    n_state = ST_BIN_RD;
                end
            end
            ST_ERR:     n_state = ST_OUT;
            ST_BIN_RD:  n_state = ST_SQ_INIT;
            ST_SQ_INIT: n_state = ST_SQ;
            ST_SQ:      if (r_cnt == CNT_W'(SQ_STEPS - 1)) n_state = ST_LOAD;
            ST_LOAD:    n_state = ST_OUT;
            ST_OUT: begin
                if (i_status.out_fire) begin
                    n_state = i_status.out_last ? ST_PRIME : ST_BIN_RD;
                end
            end
            ST_PRIME:   n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CALC: begin
                o_cmd.div_step = (r_cnt < CNT_W'(QW));
                o_cmd.mul_en   = (r_cnt < CNT_W'(MUL_STEPS));
                o_cmd.sum_en   = (r_cnt == CNT_W'(MUL_STEPS));
                if (r_cnt == '0) begin
                    o_cmd.mul_sel = MUL_RE;
                end else if (r_cnt == CNT_W'(1)) begin
                    o_cmd.mul_sel = MUL_IM;
                end else begin
                    o_cmd.mul_sel = MUL_FLOOR;
                end
            end
            ST_READ:    o_cmd.acc_rd    = 1'b1;
            ST_UPD:     o_cmd.acc_upd   = 1'b1;
            ST_DUMP:    o_cmd.dump_init = 1'b1;
            ST_ERR:     o_cmd.out_err   = 1'b1;
            ST_BIN_RD:  o_cmd.bin_rd    = 1'b1;
            ST_SQ_INIT: o_cmd.sq_init   = 1'b1;
            ST_SQ:      o_cmd.sq_step   = 1'b1;
            ST_LOAD:    o_cmd.out_load  = 1'b1;
            ST_OUT:     o_cmd.bin_next  = i_status.out_fire && !i_status.out_last;
            ST_PRIME:   o_cmd.prime     = 1'b1;
            default: ;
        endcase
    end

endmodule

[src/binned_spectral_peak_search_top.sv]
// binned spectral peak search
// each spectrum value passes through the bit-serial bin index divider and the bin store
// read-modify-write; the input takes no new value until the last one is through
// at a frame end each bin passes through the 24-step square root, and the output can stall
// synchronous active-low reset clears control state, bin valid flags and configuration
`timescale 1ns / 1ps
`include "binned_spectral_peak_search_top_assert.svh"

module binned_spectral_peak_search_top import bsps_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // bin_position, sample_real, sample_imag
    input  logic [IN_TD_W-1:0]                s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // bin_number, peak_position, peak_real, peak_imag, peak_magnitude
    output logic [out_td_w(MAX_BINS)-1:0]     m_axis_tdata,
    // found, too_many_bins
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int BIN_W    = bin_w(MAX_BINS);
    localparam int OUT_TD_W = out_td_w(MAX_BINS);

    t_cmd    cmd;
    t_status status;

    logic [BIN_W-1:0]              out_bin;
    logic                          out_found, out_too_many;
    logic [POS_W-1:0]              out_pos;
    logic signed [SAMPLE_BITS-1:0] out_re, out_im;
    logic [SAMPLE_BITS-1:0]        out_mag;

    bsps_ctrl #(
        .MAX_BINS (MAX_BINS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bsps_datapath #(
        .MAX_BINS (MAX_BINS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pos       (s_axis_tdata[POS_W-1:0]),
        .i_re        ($signed(s_axis_tdata[POS_W+SAMPLE_BITS-1:POS_W])),
        .i_im        ($signed(s_axis_tdata[POS_W+2*SAMPLE_BITS-1:POS_W+SAMPLE_BITS])),
        .i_last      (s_axis_tlast),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_bin       (out_bin),
        .o_found     (out_found),
        .o_pos       (out_pos),
        .o_re        (out_re),
        .o_im        (out_im),
        .o_mag       (out_mag),
        .o_too_many  (out_too_many),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TD_W'({out_mag, out_im, out_re, out_pos, out_bin});
    assign m_axis_tuser = {out_too_many, out_found};

    `BSPS_ASSERT_IMPLY(a_ready_no_pending, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `BSPS_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `BSPS_ASSERT_IMPLY(a_err_result, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata == '0) && m_axis_tlast && !m_axis_tuser[0])
    `BSPS_ASSERT_IMPLY(a_not_found_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[OUT_TD_W-1:BIN_W] == '0)

endmodule
